// ===== hw/rtl/dweq_pkg.sv =====
package dweq_pkg;

  localparam int GRID_POINTS = 256;
  localparam int AW = $clog2(GRID_POINTS);
  localparam int KW = $clog2(GRID_POINTS + 1);
  localparam int IDX_W = 8;
  localparam int DATA_W = 16;
  localparam int COEF_W = 16;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [AW-1:0] addr_t;
  typedef logic [KW-1:0] cnt_t;
  typedef logic signed [DATA_W-1:0] sample_t;

  localparam cnt_t CNT_LAST = cnt_t'(GRID_POINTS - 1);
  localparam cnt_t CNT_END = cnt_t'(GRID_POINTS);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COURANT_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;

  localparam logic [COEF_W-1:0] COURANT_SQ_RESET = 16'd5898;
  localparam logic [COEF_W-1:0] DAMPING_RESET = 16'd58327;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic capture;
    logic item_write;
    logic item_read;
    logic read_out;
    logic fetch_adv;
    logic fetch_rd;
    logic sweep_start;
    logic step_out;
    cnt_t count;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(GRID_POINTS);
  endfunction

endpackage

// ===== hw/rtl/damped_wave_equation_1d_step_top.sv =====
// From the accepting edge to the result strobe: a write passes ST_WRITE, a read ST_READ and ST_READ_OUT,
// a step ST_STEP (one grid point per cycle through the memory read port), ST_DRAIN until the five-stage
// stencil and damping pipeline drains, then ST_STEP_OUT; the strobe is registered after the last state.
// busy falls as the strobe rises; a new transaction is taken from the next edge on.
// After synchronous reset both grids are cleared in a pass over every address with busy high.
// The receiver cannot stall: each result is valid for exactly one cycle.
module damped_wave_equation_1d_step_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dweq_pkg::OP_W-1:0]          in_operation,
  input  logic [dweq_pkg::IDX_W-1:0]         in_point_index,
  input  logic signed [dweq_pkg::DATA_W-1:0] in_load_current,
  input  logic signed [dweq_pkg::DATA_W-1:0] in_load_previous,
  output logic                               out_valid,
  output logic [dweq_pkg::IDX_W-1:0]         out_index,
  output logic signed [dweq_pkg::DATA_W-1:0] out_current,
  output logic signed [dweq_pkg::DATA_W-1:0] out_previous,
  output logic                               out_overflow,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dweq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dweq_pkg::COEF_W-1:0]        cfg_data
);
  import dweq_pkg::*;

  cmd_t cmd;
  status_t status;

  dweq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  dweq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_point_index   (in_point_index),
    .in_load_current  (in_load_current),
    .in_load_previous (in_load_previous),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_index        (out_index),
    .out_current      (out_current),
    .out_previous     (out_previous),
    .out_overflow     (out_overflow)
  );

endmodule

// ===== hw/rtl/dweq_ctrl.sv =====
module dweq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dweq_pkg::OP_W-1:0]     in_operation,
  input  dweq_pkg::status_t             status,
  output dweq_pkg::cmd_t                cmd,
  output logic                          busy
);
  import dweq_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_WRITE    = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_READ_OUT = 3'd4;
  localparam logic [2:0] ST_STEP     = 3'd5;
  localparam logic [2:0] ST_DRAIN    = 3'd6;
  localparam logic [2:0] ST_STEP_OUT = 3'd7;

  logic [2:0] state_r, state_nxt;
  cnt_t cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.count = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (in_operation)
            OP_WRITE: state_nxt = ST_WRITE;
            OP_STEP: begin
              cmd.sweep_start = 1'b1;
              cnt_nxt = '0;
              state_nxt = ST_STEP;
            end
            default: state_nxt = ST_READ;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.item_write = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        cmd.item_read = 1'b1;
        state_nxt = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        cmd.read_out = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        // The slot at count GRID_POINTS, past the last address, flushes the final point
        // through the stencil window.
        cmd.fetch_adv = 1'b1;
        cmd.fetch_rd = (cnt_r != CNT_END);
        if (cnt_r == CNT_END) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_STEP_OUT;
        end
      end
      ST_STEP_OUT: begin
        cmd.step_out = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hw/rtl/dweq_datapath.sv =====
module dweq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dweq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dweq_pkg::COEF_W-1:0]       cfg_data,
  input  logic [dweq_pkg::IDX_W-1:0]        in_point_index,
  input  logic signed [dweq_pkg::DATA_W-1:0] in_load_current,
  input  logic signed [dweq_pkg::DATA_W-1:0] in_load_previous,
  input  dweq_pkg::cmd_t                    cmd,
  output dweq_pkg::status_t                 status,
  output logic                              out_valid,
  output logic [dweq_pkg::IDX_W-1:0]        out_index,
  output logic signed [dweq_pkg::DATA_W-1:0] out_current,
  output logic signed [dweq_pkg::DATA_W-1:0] out_previous,
  output logic                              out_overflow
);
  import dweq_pkg::*;

  // Configuration registers.
  logic [COEF_W-1:0] courant_r, damping_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_r <= COURANT_SQ_RESET;
      damping_r <= DAMPING_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_COURANT_SQ) courant_r <= cfg_data;
      if (cfg_index == REG_DAMPING) damping_r <= cfg_data;
    end
  end

  // Captured transaction fields.
  logic [IDX_W-1:0] idx_r;
  sample_t lc_r, lp_r;
  logic inr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_point_index;
      lc_r <= in_load_current;
      lp_r <= in_load_previous;
      inr_r <= idx_in_range(in_point_index);
    end
  end

  addr_t item_addr;
  assign item_addr = addr_t'(idx_r);

  // Grid memories, one read and one write port each.
  sample_t cur_mem [GRID_POINTS];
  sample_t prev_mem [GRID_POINTS];
  sample_t cur_q_r, prev_q_r;

  addr_t rd_addr;
  logic rd_en;
  assign rd_en = cmd.item_read | cmd.fetch_rd;
  assign rd_addr = cmd.item_read ? item_addr : cmd.count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_q_r <= cur_mem[rd_addr];
      prev_q_r <= prev_mem[rd_addr];
    end
  end

  // Stencil window: cm1 = cur[j-1], c0 = cur[j], cur_q = cur[j+1].
  logic adv_d_r;
  cnt_t kd_r;
  sample_t cm1_r, c0_r, pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_d_r <= 1'b0;
    end else begin
      adv_d_r <= cmd.fetch_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_adv) kd_r <= cmd.count;
    if (adv_d_r) begin
      cm1_r <= c0_r;
      c0_r <= cur_q_r;
      pd_r <= prev_q_r;
    end
  end

  cnt_t j_s1;
  logic v_s1, int_s1;
  logic signed [18:0] lap_s1, base_s1;

  assign j_s1 = kd_r - cnt_t'(1);
  assign v_s1 = adv_d_r && (kd_r != '0);
  assign int_s1 = (j_s1 != '0) && (j_s1 < CNT_LAST);
  assign lap_s1 = {{3{cur_q_r[DATA_W-1]}}, cur_q_r} + {{3{cm1_r[DATA_W-1]}}, cm1_r}
                - {{2{c0_r[DATA_W-1]}}, c0_r, 1'b0};
  assign base_s1 = {{2{c0_r[DATA_W-1]}}, c0_r, 1'b0} - {{3{pd_r[DATA_W-1]}}, pd_r};

  // Stage registers.
  logic v1_r, v2_r, v3_r, v4_r;
  logic int1_r, int2_r;
  addr_t j1_r, j2_r, j3_r, j4_r;
  logic signed [18:0] lap1_r, base1_r, base2_r;
  logic signed [35:0] prod2_r;
  logic signed [19:0] n3_r;
  logic signed [36:0] m4_r;

  logic signed [35:0] prod_rnd;
  logic signed [19:0] n_s3;
  logic signed [36:0] m_rnd;
  logic signed [20:0] q_s5;
  sample_t sat_s5;
  logic sat_hit;

  assign prod_rnd = prod2_r + 36'sd32768;
  assign n_s3 = int2_r ? ({base2_r[18], base2_r} + prod_rnd[35:16]) : '0;
  assign m_rnd = m4_r + 37'sd32768;
  assign q_s5 = m_rnd[36:16];

  always_comb begin
    sat_hit = 1'b0;
    sat_s5 = q_s5[DATA_W-1:0];
    if (q_s5 > 21'sd32767) begin
      sat_hit = 1'b1;
      sat_s5 = 16'sh7FFF;
    end else if (q_s5 < -21'sd32768) begin
      sat_hit = 1'b1;
      sat_s5 = 16'sh8000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v_s1;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r <= j_s1[AW-1:0];
    int1_r <= int_s1;
    lap1_r <= lap_s1;
    base1_r <= base_s1;
    j2_r <= j1_r;
    int2_r <= int1_r;
    base2_r <= base1_r;
    prod2_r <= 36'(lap1_r) * 36'($signed({1'b0, courant_r}));
    j3_r <= j2_r;
    n3_r <= n_s3;
    j4_r <= j3_r;
    m4_r <= 37'(n3_r) * 37'($signed({1'b0, damping_r}));
  end

  assign status.pipe_busy = adv_d_r | v1_r | v2_r | v3_r | v4_r;

  // Step summary for point zero and the saturation flag.
  logic ovf_r;
  sample_t step_cur0_r, step_prev0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      ovf_r <= 1'b0;
    end else if (v4_r && sat_hit) begin
      ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && (j4_r == '0)) step_cur0_r <= sat_s5;
    if (v_s1 && (j_s1 == '0)) step_prev0_r <= pd_r;
  end

  // Memory write ports.
  logic cur_we, prev_we, prev_step_we;
  addr_t cur_wa, prev_wa;
  sample_t cur_wd, prev_wd;

  assign prev_step_we = v_s1 && int_s1;

  always_comb begin
    cur_we = 1'b0;
    cur_wa = cmd.count[AW-1:0];
    cur_wd = '0;
    if (cmd.clear_we) begin
      cur_we = 1'b1;
    end else if (cmd.item_write && inr_r) begin
      cur_we = 1'b1;
      cur_wa = item_addr;
      cur_wd = lc_r;
    end else if (v4_r) begin
      cur_we = 1'b1;
      cur_wa = j4_r;
      cur_wd = sat_s5;
    end
  end

  always_comb begin
    prev_we = 1'b0;
    prev_wa = cmd.count[AW-1:0];
    prev_wd = '0;
    if (cmd.clear_we) begin
      prev_we = 1'b1;
    end else if (cmd.item_write && inr_r) begin
      prev_we = 1'b1;
      prev_wa = item_addr;
      prev_wd = lp_r;
    end else if (prev_step_we) begin
      prev_we = 1'b1;
      prev_wa = j_s1[AW-1:0];
      prev_wd = c0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  // Result register.
  logic out_valid_r, out_overflow_r;
  logic [IDX_W-1:0] out_index_r;
  sample_t out_current_r, out_previous_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.item_write | cmd.read_out | cmd.step_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_write) begin
      out_index_r <= idx_r;
      out_current_r <= inr_r ? lc_r : '0;
      out_previous_r <= inr_r ? lp_r : '0;
      out_overflow_r <= 1'b0;
    end else if (cmd.read_out) begin
      out_index_r <= idx_r;
      out_current_r <= inr_r ? cur_q_r : '0;
      out_previous_r <= inr_r ? prev_q_r : '0;
      out_overflow_r <= 1'b0;
    end else if (cmd.step_out) begin
      out_index_r <= '0;
      out_current_r <= step_cur0_r;
      out_previous_r <= step_prev0_r;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_current = out_current_r;
  assign out_previous = out_previous_r;
  assign out_overflow = out_overflow_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_ovf_step_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_overflow_r) |-> (out_index_r == '0))
    else $error("overflow reported on a non-step result");

  a_step_out_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_out |-> !status.pipe_busy)
    else $error("step result issued with points still in flight");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && int1_r) |-> ((j1_r != '0) && (j1_r != CNT_LAST[AW-1:0])))
    else $error("stencil applied to an end point");

endmodule
